@@ hdl/i2cm_pkg.sv @@
// Shared types and codes for the I2C master register access sequencer.
// No dependencies; imported by i2cm_step, the top level and the testbench.
package i2cm_pkg;

   // Default for the largest data byte count per access.
   localparam int MAX_BYTES_DEF = 4;

   // Bus event codes carried on the mode field.
   localparam logic [2:0] EV_START     = 3'd0;
   localparam logic [2:0] EV_ACK       = 3'd1;
   localparam logic [2:0] EV_NACK      = 3'd2;
   localparam logic [2:0] EV_RX_BYTE   = 3'd3;
   localparam logic [2:0] EV_STOP_DONE = 3'd4;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_ADDR,
      PH_REG,
      PH_RESTART,
      PH_RECV,
      PH_SEND,
      PH_STOP
   } phase_type;

   // Bus commands and status flags produced for one event.
   typedef struct packed {
      logic issue_start;
      logic tx_valid;
      logic issue_ack;
      logic issue_nack;
      logic issue_stop;
      logic done;
      logic error;
   } flags_type;

endpackage

@@ hdl/i2cm_step.sv @@
// Event decode for the register access sequencer: next phase, counters and
// bus commands for one event. Depends on i2cm_pkg.
module i2cm_step import i2cm_pkg::*; #(
   parameter int MAX_BYTES = MAX_BYTES_DEF,
   parameter int CNT_W     = $clog2(MAX_BYTES + 1)
) (
   input  logic [2:0]       mode,
   input  logic [6:0]       new_dev_addr,
   input  logic             new_is_read,
   input  logic [2:0]       new_byte_count,
   input  logic [7:0]       rx_byte,
   input  phase_type        phase_ff,
   input  logic             busy_ff,
   input  logic [6:0]       dev_addr_ff,
   input  logic [7:0]       reg_addr_ff,
   input  logic             is_read_ff,
   input  logic [CNT_W-1:0] total_ff,
   input  logic [CNT_W-1:0] count_ff,
   input  logic [31:0]      wword_ff,
   input  logic [31:0]      accum_ff,
   output logic             load,
   output phase_type        phase_in,
   output logic             busy_in,
   output logic [CNT_W-1:0] total_in,
   output logic [CNT_W-1:0] count_in,
   output logic [31:0]      accum_in,
   output flags_type        flags,
   output logic [7:0]       tx_byte
);

   logic [CNT_W-1:0] count_inc;
   logic             last;
   logic [3:0]       bc_ext;

   // Byte j counted from the least significant end; zero beyond the word.
   function automatic logic [7:0] pick(input logic [31:0] w, input logic [CNT_W-1:0] j);
      logic [4:0] sh;
      sh = 5'({j, 3'b000});
      pick = (32'(j) < 32'd4) ? 8'(w >> sh) : 8'h00;
   endfunction

   assign count_inc = count_ff + CNT_W'(1);
   assign last      = (count_inc >= total_ff);
   assign bc_ext    = {1'b0, new_byte_count};

   // Clamp the requested count into one to MAX_BYTES.
   always_comb begin
      if (bc_ext == 4'd0) begin
         total_in = CNT_W'(1);
      end else if (bc_ext > 4'(MAX_BYTES)) begin
         total_in = CNT_W'(MAX_BYTES);
      end else begin
         total_in = CNT_W'(bc_ext);
      end
   end

   // Next state.
   always_comb begin
      load     = 1'b0;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      count_in = count_ff;
      accum_in = accum_ff;
      unique case (mode)
         EV_START: begin
            if (!busy_ff) begin
               load     = 1'b1;
               busy_in  = 1'b1;
               phase_in = PH_ADDR;
               count_in = '0;
               if (new_is_read) begin
                  accum_in = '0;
               end
            end
         end
         EV_ACK: begin
            unique case (phase_ff)
               PH_ADDR:    phase_in = PH_REG;
               PH_REG:     phase_in = is_read_ff ? PH_RESTART : PH_SEND;
               PH_RESTART: phase_in = PH_RECV;
               PH_SEND: begin
                  count_in = count_inc;
                  if (last) begin
                     phase_in = PH_STOP;
                  end
               end
               default: ;
            endcase
         end
         EV_RX_BYTE: begin
            if (phase_ff == PH_RECV) begin
               accum_in = {accum_ff[23:0], rx_byte};
               count_in = count_inc;
               if (last) begin
                  phase_in = PH_STOP;
               end
            end
         end
         EV_STOP_DONE: begin
            if (busy_ff) begin
               busy_in  = 1'b0;
               phase_in = PH_IDLE;
            end
         end
         default: ;
      endcase
   end

   // Bus commands.
   always_comb begin
      flags   = '0;
      tx_byte = 8'h00;
      unique case (mode)
         EV_START: begin
            if (busy_ff) begin
               flags.error = 1'b1;
            end else begin
               flags.issue_start = 1'b1;
               flags.tx_valid    = 1'b1;
               tx_byte           = {new_dev_addr, 1'b0};
            end
         end
         EV_ACK: begin
            unique case (phase_ff)
               PH_ADDR: begin
                  flags.tx_valid = 1'b1;
                  tx_byte        = reg_addr_ff;
               end
               PH_REG: begin
                  flags.tx_valid = 1'b1;
                  if (is_read_ff) begin
                     flags.issue_start = 1'b1;
                     tx_byte           = {dev_addr_ff, 1'b1};
                  end else begin
                     tx_byte = pick(wword_ff, total_ff - CNT_W'(1));
                  end
               end
               PH_RESTART: ;
               PH_SEND: begin
                  if (last) begin
                     flags.issue_stop = 1'b1;
                  end else begin
                     flags.tx_valid = 1'b1;
                     tx_byte        = pick(wword_ff, total_ff - CNT_W'(1) - count_inc);
                  end
               end
               default: flags.error = 1'b1;
            endcase
         end
         EV_NACK: begin
            if (phase_ff == PH_RESTART) begin
               flags.issue_start = 1'b1;
               flags.tx_valid    = 1'b1;
               tx_byte           = {dev_addr_ff, 1'b1};
            end else begin
               flags.error = 1'b1;
            end
         end
         EV_RX_BYTE: begin
            if (phase_ff != PH_RECV) begin
               flags.error = 1'b1;
            end else if (last) begin
               flags.issue_nack = 1'b1;
               flags.issue_stop = 1'b1;
            end else begin
               flags.issue_ack = 1'b1;
            end
         end
         EV_STOP_DONE: begin
            if (busy_ff) begin
               flags.done  = 1'b1;
               flags.error = (phase_ff != PH_STOP);
            end else begin
               flags.error = 1'b1;
            end
         end
         default: flags.error = 1'b1;
      endcase
   end

endmodule

@@ hdl/i2c_master_register_access_fsm.sv @@
// An accepted item's result is registered for the next cycle and frees once it is taken.
// Throughput: one event item per cycle while the single result register is not stalled.
// Reset (synchronous, active high): phase idle, not busy, counters and read data zero,
// no result pending.
// Depends on i2cm_pkg and i2cm_step.
module i2c_master_register_access_fsm import i2cm_pkg::*; #(
   parameter int MAX_BYTES = MAX_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_mode,
   input  logic [6:0]  req_dev_addr,
   input  logic [7:0]  req_reg_addr,
   input  logic        req_is_read,
   input  logic [2:0]  req_byte_count,
   input  logic [31:0] req_write_word,
   input  logic [7:0]  req_rx_byte,
   input  logic [31:0] req_event_id,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_issue_start,
   output logic        rsp_tx_valid,
   output logic [7:0]  rsp_tx_byte,
   output logic        rsp_issue_ack,
   output logic        rsp_issue_nack,
   output logic        rsp_issue_stop,
   output logic [31:0] rsp_read_word,
   output logic        rsp_busy_res,
   output logic        rsp_done_res,
   output logic [31:0] rsp_done_event,
   output logic        rsp_error
);

   localparam int CNT_W = $clog2(MAX_BYTES + 1);

   // Transaction state.
   phase_type        phase_ff;
   logic             busy_ff;
   logic [6:0]       dev_addr_ff;
   logic [7:0]       reg_addr_ff;
   logic             is_read_ff;
   logic [CNT_W-1:0] total_ff;
   logic [CNT_W-1:0] count_ff;
   logic [31:0]      wword_ff;
   logic [31:0]      accum_ff;
   logic [31:0]      event_id_ff;

   // Next values from the event decode.
   logic             load;
   phase_type        phase_in;
   logic             busy_in;
   logic [CNT_W-1:0] total_in;
   logic [CNT_W-1:0] count_in;
   logic [31:0]      accum_in;
   flags_type        flags;
   logic [7:0]       tx_byte;

   // Result register.
   logic             rsp_valid_ff;
   flags_type        rsp_flags_ff;
   logic [7:0]       rsp_tx_byte_ff;
   logic [31:0]      rsp_read_word_ff;
   logic             rsp_busy_ff;
   logic [31:0]      rsp_done_event_ff;

   logic             req_acc;

   // Accept a new item whenever the result slot is empty or drains this cycle.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_acc   = req_valid && !req_stall;

   i2cm_step #(
      .MAX_BYTES (MAX_BYTES),
      .CNT_W     (CNT_W)
   ) u_step (
      .mode           (req_mode),
      .new_dev_addr   (req_dev_addr),
      .new_is_read    (req_is_read),
      .new_byte_count (req_byte_count),
      .rx_byte        (req_rx_byte),
      .phase_ff       (phase_ff),
      .busy_ff        (busy_ff),
      .dev_addr_ff    (dev_addr_ff),
      .reg_addr_ff    (reg_addr_ff),
      .is_read_ff     (is_read_ff),
      .total_ff       (total_ff),
      .count_ff       (count_ff),
      .wword_ff       (wword_ff),
      .accum_ff       (accum_ff),
      .load           (load),
      .phase_in       (phase_in),
      .busy_in        (busy_in),
      .total_in       (total_in),
      .count_in       (count_in),
      .accum_in       (accum_in),
      .flags          (flags),
      .tx_byte        (tx_byte)
   );

   // Control state: advance on each accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         busy_ff  <= 1'b0;
         total_ff <= '0;
         count_ff <= '0;
         accum_ff <= '0;
      end else if (req_acc) begin
         phase_ff <= phase_in;
         busy_ff  <= busy_in;
         count_ff <= count_in;
         accum_ff <= accum_in;
         if (load) begin
            total_ff <= total_in;
         end
      end
   end

   // Access parameters: capture on a start taken while idle.
   always_ff @(posedge clock) begin
      if (req_acc && load) begin
         dev_addr_ff <= req_dev_addr;
         reg_addr_ff <= req_reg_addr;
         is_read_ff  <= req_is_read;
         wword_ff    <= req_write_word;
         event_id_ff <= req_event_id;
      end
   end

   // Result slot: fill on accept, drop once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_acc) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         rsp_flags_ff      <= flags;
         rsp_tx_byte_ff    <= tx_byte;
         rsp_read_word_ff  <= accum_in;
         rsp_busy_ff       <= busy_in;
         rsp_done_event_ff <= flags.done ? event_id_ff : 32'h0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_issue_start = rsp_flags_ff.issue_start;
   assign rsp_tx_valid    = rsp_flags_ff.tx_valid;
   assign rsp_tx_byte     = rsp_tx_byte_ff;
   assign rsp_issue_ack   = rsp_flags_ff.issue_ack;
   assign rsp_issue_nack  = rsp_flags_ff.issue_nack;
   assign rsp_issue_stop  = rsp_flags_ff.issue_stop;
   assign rsp_read_word   = rsp_read_word_ff;
   assign rsp_busy_res    = rsp_busy_ff;
   assign rsp_done_res    = rsp_flags_ff.done;
   assign rsp_done_event  = rsp_done_event_ff;
   assign rsp_error       = rsp_flags_ff.error;

endmodule

@@ hdl/i2cm_checker.sv @@
// Port-level checks for the register access sequencer, bound to the top level.
// Depends only on the top level's ports.
module i2cm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_issue_start,
   input logic        rsp_tx_valid,
   input logic [7:0]  rsp_tx_byte,
   input logic        rsp_issue_nack,
   input logic        rsp_issue_stop,
   input logic        rsp_busy_res,
   input logic        rsp_done_res
);

   // A NACK of the last byte always comes with STOP.
   a_nack_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_issue_nack |-> rsp_issue_stop)
      else $error("nack without stop");

   // No byte to send reads as zero.
   a_tx_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_tx_valid |-> rsp_tx_byte == 8'h00)
      else $error("tx byte without tx valid");

   // A finished transaction leaves the block free.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res |-> !rsp_busy_res && !rsp_issue_start)
      else $error("done while busy");

   // A start condition always carries an address byte inside a transaction.
   a_start_tx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_issue_start |-> rsp_tx_valid && rsp_busy_res)
      else $error("start without address");

   // Hold a stalled result.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_tx_byte))
      else $error("stalled result changed");

endmodule

bind i2c_master_register_access_fsm i2cm_checker u_i2cm_checker (.*);

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the I2C master register access sequencer.
// Depends on i2cm_pkg and the i2c_master_register_access_fsm RTL; needs nothing else.
module tb;
   import i2cm_pkg::*;

   // Event codes past stop-done: the block must flag every one of them.
   localparam logic [2:0] EV_RSVD_LO = 3'd5;
   localparam logic [2:0] EV_RSVD_HI = 3'd7;

   // Stop feeding random transfers once this many event items went in.
   localparam int ITEM_TARGET = 1050;

   // One bus event as it is offered on the request side.
   typedef struct packed {
      logic [2:0]  mode;
      logic [6:0]  dev_addr;
      logic [7:0]  reg_addr;
      logic        is_read;
      logic [2:0]  byte_count;
      logic [31:0] write_word;
      logic [7:0]  rx_byte;
      logic [31:0] event_id;
   } bus_event_type;

   // Commands and status returned for one event.
   typedef struct packed {
      logic        issue_start;
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        issue_ack;
      logic        issue_nack;
      logic        issue_stop;
      logic [31:0] read_word;
      logic        busy;
      logic        done;
      logic [31:0] done_event;
      logic        error;
   } bus_result_type;

   // Shadow copy of the sequencer: tracks the register access in flight and
   // keeps the commands every accepted event must produce, oldest first.
   class i2c_seq_ledger;
      phase_type      phase;
      logic [6:0]     dev;
      logic [7:0]     reg_idx;
      logic           rd;
      int unsigned    total;
      int unsigned    done_cnt;
      logic [31:0]    wr_word;
      logic [31:0]    rx_word;
      logic [31:0]    done_id;
      logic           busy;
      bus_result_type owed[$];
      int             mismatches;
      int             checked;
      int             completions;
      int             flagged;

      function new();
         phase       = PH_IDLE;
         dev         = '0;
         reg_idx     = '0;
         rd          = 1'b0;
         total       = 0;
         done_cnt    = 0;
         wr_word     = '0;
         rx_word     = '0;
         done_id     = '0;
         busy        = 1'b0;
         mismatches  = 0;
         checked     = 0;
         completions = 0;
         flagged     = 0;
      endfunction

      // Data byte k of the write word, most significant used byte first.
      function logic [7:0] wr_byte(int unsigned k);
         int unsigned sh;
         if (k >= total) return 8'h00;
         sh = 8 * (total - 1 - k);
         if (sh >= 32) return 8'h00;
         return 8'(wr_word >> sh);
      endfunction

      function void note_event(bus_event_type ev);
         bus_result_type r;
         r = '0;
         case (ev.mode)
            EV_START: begin
               if (busy) begin
                  r.error = 1'b1;
               end else begin
                  dev      = ev.dev_addr;
                  reg_idx  = ev.reg_addr;
                  rd       = ev.is_read;
                  total    = ev.byte_count;
                  if (total == 0) total = 1;
                  if (total > MAX_BYTES_DEF) total = MAX_BYTES_DEF;
                  done_cnt = 0;
                  wr_word  = ev.write_word;
                  done_id  = ev.event_id;
                  if (rd) rx_word = '0;
                  busy     = 1'b1;
                  phase    = PH_ADDR;
                  r.issue_start = 1'b1;
                  r.tx_valid    = 1'b1;
                  r.tx_byte     = {dev, 1'b0};
               end
            end
            EV_ACK: begin
               case (phase)
                  PH_ADDR: begin
                     phase      = PH_REG;
                     r.tx_valid = 1'b1;
                     r.tx_byte  = reg_idx;
                  end
                  PH_REG: begin
                     if (rd) begin
                        phase         = PH_RESTART;
                        r.issue_start = 1'b1;
                        r.tx_valid    = 1'b1;
                        r.tx_byte     = {dev, 1'b1};
                     end else begin
                        phase      = PH_SEND;
                        r.tx_valid = 1'b1;
                        r.tx_byte  = wr_byte(0);
                     end
                  end
                  PH_RESTART: begin
                     phase = PH_RECV;
                  end
                  PH_SEND: begin
                     done_cnt++;
                     if (done_cnt >= total) begin
                        phase        = PH_STOP;
                        r.issue_stop = 1'b1;
                     end else begin
                        r.tx_valid = 1'b1;
                        r.tx_byte  = wr_byte(done_cnt);
                     end
                  end
                  default: r.error = 1'b1;
               endcase
            end
            EV_NACK: begin
               if (phase == PH_RESTART) begin
                  r.issue_start = 1'b1;
                  r.tx_valid    = 1'b1;
                  r.tx_byte     = {dev, 1'b1};
               end else begin
                  r.error = 1'b1;
               end
            end
            EV_RX_BYTE: begin
               if (phase == PH_RECV) begin
                  rx_word = {rx_word[23:0], ev.rx_byte};
                  done_cnt++;
                  if (done_cnt >= total) begin
                     phase        = PH_STOP;
                     r.issue_nack = 1'b1;
                     r.issue_stop = 1'b1;
                  end else begin
                     r.issue_ack = 1'b1;
                  end
               end else begin
                  r.error = 1'b1;
               end
            end
            EV_STOP_DONE: begin
               if (busy) begin
                  if (phase != PH_STOP) r.error = 1'b1;
                  busy         = 1'b0;
                  phase        = PH_IDLE;
                  r.done       = 1'b1;
                  r.done_event = done_id;
               end else begin
                  r.error = 1'b1;
               end
            end
            default: r.error = 1'b1;
         endcase
         r.read_word = rx_word;
         r.busy      = busy;
         if (r.done)  completions++;
         if (r.error) flagged++;
         owed.push_back(r);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $time, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("result %0d %s: got %h, want %h", checked, name, got, want));
      endtask

      task check_result(bus_result_type got);
         bus_result_type want;
         if (owed.size() == 0) begin
            report($sformatf("result with no event pending: %h", got));
            return;
         end
         want = owed.pop_front();
         checked++;
         compare_field("issue_start", 32'(got.issue_start), 32'(want.issue_start));
         compare_field("tx_valid",    32'(got.tx_valid),    32'(want.tx_valid));
         compare_field("tx_byte",     32'(got.tx_byte),     32'(want.tx_byte));
         compare_field("issue_ack",   32'(got.issue_ack),   32'(want.issue_ack));
         compare_field("issue_nack",  32'(got.issue_nack),  32'(want.issue_nack));
         compare_field("issue_stop",  32'(got.issue_stop),  32'(want.issue_stop));
         compare_field("read_word",   got.read_word,        want.read_word);
         compare_field("busy_res",    32'(got.busy),        32'(want.busy));
         compare_field("done_res",    32'(got.done),        32'(want.done));
         compare_field("done_event",  got.done_event,       want.done_event);
         compare_field("error",       32'(got.error),       32'(want.error));
      endtask
   endclass

   // Clock, reset and every block input start at known values.
   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [2:0]  req_mode       = EV_START;
   logic [6:0]  req_dev_addr   = '0;
   logic [7:0]  req_reg_addr   = '0;
   logic        req_is_read    = 1'b0;
   logic [2:0]  req_byte_count = '0;
   logic [31:0] req_write_word = '0;
   logic [7:0]  req_rx_byte    = '0;
   logic [31:0] req_event_id   = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic        rsp_issue_start;
   logic        rsp_tx_valid;
   logic [7:0]  rsp_tx_byte;
   logic        rsp_issue_ack;
   logic        rsp_issue_nack;
   logic        rsp_issue_stop;
   logic [31:0] rsp_read_word;
   logic        rsp_busy_res;
   logic        rsp_done_res;
   logic [31:0] rsp_done_event;
   logic        rsp_error;

   i2c_seq_ledger ledger;
   int            items_sent = 0;
   // Items left in the current no-wait stretch, one count per side.
   int            req_calm   = 0;
   int            rsp_calm   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   i2c_master_register_access_fsm #(
      .MAX_BYTES(MAX_BYTES_DEF)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_dev_addr   (req_dev_addr),
      .req_reg_addr   (req_reg_addr),
      .req_is_read    (req_is_read),
      .req_byte_count (req_byte_count),
      .req_write_word (req_write_word),
      .req_rx_byte    (req_rx_byte),
      .req_event_id   (req_event_id),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_issue_start(rsp_issue_start),
      .rsp_tx_valid   (rsp_tx_valid),
      .rsp_tx_byte    (rsp_tx_byte),
      .rsp_issue_ack  (rsp_issue_ack),
      .rsp_issue_nack (rsp_issue_nack),
      .rsp_issue_stop (rsp_issue_stop),
      .rsp_read_word  (rsp_read_word),
      .rsp_busy_res   (rsp_busy_res),
      .rsp_done_res   (rsp_done_res),
      .rsp_done_event (rsp_done_event),
      .rsp_error      (rsp_error)
   );

   // Draw the wait before the next item on one side. Now and then enter a
   // stretch of back-to-back items so that the block also sees full rate.
   function automatic int draw_wait(input bit rsp_side);
      int left;
      left = rsp_side ? rsp_calm : req_calm;
      if (left > 0) begin
         left--;
      end else if ($urandom_range(0, 15) == 0) begin
         left = $urandom_range(10, 40);
      end else begin
         return $urandom_range(0, 19);
      end
      if (rsp_side) rsp_calm = left;
      else req_calm = left;
      return 0;
   endfunction

   // Fill every field at random; fields the event does not use must be ignored.
   function automatic bus_event_type any_event(input logic [2:0] mode);
      bus_event_type e;
      e.mode       = mode;
      e.dev_addr   = 7'($urandom);
      e.reg_addr   = 8'($urandom);
      e.is_read    = 1'($urandom);
      e.byte_count = 3'($urandom);
      e.write_word = $urandom;
      e.rx_byte    = 8'($urandom);
      e.event_id   = $urandom;
      return e;
   endfunction

   // Offer one event item. Called at a rising edge; returns at the edge that
   // accepted it. Drop valid only when a wait is drawn, so a back-to-back item
   // keeps valid high without a second assignment in the same step.
   task automatic push_event(input bus_event_type e);
      int gap;
      gap = draw_wait(1'b0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_mode       <= e.mode;
      req_dev_addr   <= e.dev_addr;
      req_reg_addr   <= e.reg_addr;
      req_is_read    <= e.is_read;
      req_byte_count <= e.byte_count;
      req_write_word <= e.write_word;
      req_rx_byte    <= e.rx_byte;
      req_event_id   <= e.event_id;
      req_valid      <= 1'b1;
      // Hold the payload until an edge sees it with stall low.
      do @(posedge clock); while (req_stall !== 1'b0);
      ledger.note_event(e);
      items_sent++;
   endtask

   task automatic push_mode(input logic [2:0] mode);
      push_event(any_event(mode));
   endtask

   // One register access as a well-formed event sequence with random content:
   // address ACK, register ACK, then for reads optional NACKs on the repeated
   // start, its ACK and one byte per count, for writes one ACK per data byte, then
   // stop-done. Now and then cut it short, and sprinkle stray events in.
   task automatic run_transfer();
      bus_event_type plan[$];
      bus_event_type e;
      int            n_bytes;
      int            n_nacks;
      int            cut;
      e = any_event(EV_START);
      // Mostly legal counts; the rest exercise the clamp at both ends.
      if ($urandom_range(0, 7) != 0) e.byte_count = 3'($urandom_range(1, MAX_BYTES_DEF));
      if (e.byte_count == 0) n_bytes = 1;
      else if (e.byte_count > MAX_BYTES_DEF) n_bytes = MAX_BYTES_DEF;
      else n_bytes = e.byte_count;
      plan.push_back(e);
      plan.push_back(any_event(EV_ACK));
      plan.push_back(any_event(EV_ACK));
      if (e.is_read) begin
         n_nacks = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
         repeat (n_nacks) plan.push_back(any_event(EV_NACK));
         plan.push_back(any_event(EV_ACK));
         repeat (n_bytes) plan.push_back(any_event(EV_RX_BYTE));
      end else begin
         repeat (n_bytes) plan.push_back(any_event(EV_ACK));
      end
      // Abort mid-transfer: stop-done arrives before the stop was commanded.
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, plan.size() - 1);
         while (plan.size() > cut) void'(plan.pop_back());
      end
      plan.push_back(any_event(EV_STOP_DONE));
      foreach (plan[i]) begin
         if ($urandom_range(0, 29) == 0) push_mode(3'($urandom_range(0, EV_RSVD_HI)));
         push_event(plan[i]);
      end
   endtask

   // Result side: draw a stall length per item, hold stall that long, then
   // take the next result and check it against the oldest expectation.
   initial begin
      int             hold;
      bus_result_type got;
      while (reset) @(posedge clock);
      forever begin
         hold = draw_wait(1'b1);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         got.issue_start = rsp_issue_start;
         got.tx_valid    = rsp_tx_valid;
         got.tx_byte     = rsp_tx_byte;
         got.issue_ack   = rsp_issue_ack;
         got.issue_nack  = rsp_issue_nack;
         got.issue_stop  = rsp_issue_stop;
         got.read_word   = rsp_read_word;
         got.busy        = rsp_busy_res;
         got.done        = rsp_done_res;
         got.done_event  = rsp_done_event;
         got.error       = rsp_error;
         ledger.check_result(got);
      end
   end

   // Stimulus and end of run.
   initial begin
      bus_event_type e;
      ledger = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Stray events in idle: every one of them is an error.
      push_mode(EV_ACK);
      push_mode(EV_NACK);
      push_mode(EV_RX_BYTE);
      push_mode(EV_STOP_DONE);
      for (int m = EV_RSVD_LO; m <= EV_RSVD_HI; m++) push_mode(3'(m));

      // Write at the top of every field; count zero is taken as one byte.
      e = any_event(EV_START);
      e.dev_addr   = '1;
      e.reg_addr   = '1;
      e.is_read    = 1'b0;
      e.byte_count = '0;
      e.write_word = '1;
      e.event_id   = '1;
      push_event(e);
      push_mode(EV_START);      // start while busy
      push_mode(EV_ACK);        // register byte
      push_mode(EV_ACK);        // first data byte
      push_mode(EV_NACK);       // nack while sending
      push_mode(EV_RX_BYTE);    // byte received while sending
      push_mode(EV_ACK);        // last byte acked, stop
      push_mode(EV_ACK);        // ack after stop
      push_mode(EV_STOP_DONE);

      // Read at the bottom of every field; count seven clamps to the maximum,
      // and a NACK on the repeated start resends it.
      e = any_event(EV_START);
      e.dev_addr   = '0;
      e.reg_addr   = '0;
      e.is_read    = 1'b1;
      e.byte_count = '1;
      e.write_word = '0;
      e.event_id   = '0;
      push_event(e);
      push_mode(EV_ACK);
      push_mode(EV_ACK);
      push_mode(EV_NACK);
      push_mode(EV_ACK);
      for (int k = 0; k < MAX_BYTES_DEF; k++) begin
         e = any_event(EV_RX_BYTE);
         e.rx_byte = (k % 2 == 0) ? 8'hFF : 8'h00;
         push_event(e);
      end
      push_mode(EV_STOP_DONE);

      // Random transfers, with stray events between some of them.
      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 9) == 0) push_mode(3'($urandom_range(0, EV_RSVD_HI)));
         run_transfer();
      end
      req_valid <= 1'b0;

      // Drain, then give a late or extra result time to show up.
      while (ledger.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Ran %0d event items, checked %0d results:",
               items_sent, ledger.checked);
      $display("%0d accesses completed, %0d errors flagged.",
               ledger.completions, ledger.flagged);
      if (ledger.mismatches == 0 && ledger.owed.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("%0d mismatches found.", ledger.mismatches);
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Guard against a hung handshake; far beyond the slowest legal run.
   initial begin
      #5_000_000;
      $display("Timed out with %0d results still pending.", ledger.owed.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule
